// ----- rtl/calendar_date_add_and_diff_defines.svh -----
// assertion macros for the calendar date block
`ifndef CALENDAR_DATE_ADD_AND_DIFF_DEFINES_SVH
`define CALENDAR_DATE_ADD_AND_DIFF_DEFINES_SVH

`ifndef SYNTHESIS

`define CDAD_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("calendar date block assertion failed");

`define CDAD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("calendar date block assertion failed");

`define CDAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("calendar date block assertion failed");

`else

`define CDAD_ASSERT(label, expr)
`define CDAD_ASSERT_IMP(label, ante, cons)
`define CDAD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/cdad_pkg.sv -----
package cdad_pkg;

    localparam int unsigned MAX_YEAR_DEF       = 5000;
    localparam int unsigned ADD_COUNT_BITS_DEF = 16;

    localparam int unsigned YEAR_BITS  = 13;
    localparam int unsigned MONTH_BITS = 4;
    localparam int unsigned DAY_BITS   = 5;
    localparam int unsigned ADD_BITS   = 16;
    localparam int unsigned DIFF_BITS  = 21;
    localparam int unsigned MONTHS     = 12;

    localparam logic [DIFF_BITS-1:0] DIFF_MAX = '1;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_DIFF = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STG_400 = 2'd0,
        STG_100 = 2'd1,
        STG_4   = 2'd2,
        STG_1   = 2'd3
    } t_stage;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_FWD,
        S_SER,
        S_SUM,
        S_LIM,
        S_REV,
        S_MON,
        S_DIFF,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op                   operation;
        logic [YEAR_BITS-1:0]  first_year;
        logic [MONTH_BITS-1:0] first_month;
        logic [DAY_BITS-1:0]   first_day;
        logic [YEAR_BITS-1:0]  second_year;
        logic [MONTH_BITS-1:0] second_month;
        logic [DAY_BITS-1:0]   second_day;
        logic [ADD_BITS-1:0]   days_to_add;
    } t_in;

    typedef struct packed {
        logic [YEAR_BITS-1:0]  result_year;
        logic [MONTH_BITS-1:0] result_month;
        logic [DAY_BITS-1:0]   result_day;
        logic [DIFF_BITS-1:0]  day_difference;
        logic                  error_flag;
    } t_out;

    typedef struct packed {
        logic load;
        logic sel_second;
        logic fwd_init;
        logic fwd_step;
        logic ser_store;
        logic sum;
        logic rev_init;
        logic rev_step;
        logic mon_step;
        logic res_err;
        logic res_sat;
        logic res_date;
        logic res_diff;
        logic push;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic in_ok;
        logic fwd_done;
        logic day_ok;
        logic over_lim;
        logic rev_done;
        logic mon_done;
        logic out_free;
    } t_sts;

    // years covered by one step of each stage
    function automatic logic [8:0] year_step(input t_stage s);
        logic [8:0] v;
        case (s)
            STG_400: v = 9'd400;
            STG_100: v = 9'd100;
            STG_4:   v = 9'd4;
            STG_1:   v = 9'd1;
            default: v = 9'd1;
        endcase
        return v;
    endfunction

    // days covered by one step of each stage
    function automatic logic [17:0] day_step(input t_stage s);
        logic [17:0] v;
        case (s)
            STG_400: v = 18'd146097;
            STG_100: v = 18'd36524;
            STG_4:   v = 18'd1461;
            STG_1:   v = 18'd365;
            default: v = 18'd365;
        endcase
        return v;
    endfunction

    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                      input logic leap);
        logic [DAY_BITS-1:0] v;
        case (m)
            4'd2:                               v = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:            v = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
            4'd10, 4'd12:                       v = 5'd31;
            default:                            v = 5'd0;
        endcase
        return v;
    endfunction

    // days of a common year before the first of the month
    function automatic logic [8:0] days_before(input logic [MONTH_BITS-1:0] m);
        logic [8:0] v;
        case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // leap test on (year - 1) mod 400
    function automatic logic is_leap_rem(input logic [8:0] r);
        logic v;
        v = (r[1:0] == 2'b11) && !(r inside {9'd99, 9'd199, 9'd299});
        return v;
    endfunction

endpackage

// ----- rtl/cdad_ctrl.sv -----
`include "calendar_date_add_and_diff_defines.svh"

module cdad_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  cdad_pkg::t_sts  i_sts,
    output cdad_pkg::t_cmd  o_cmd
);
    import cdad_pkg::*;

    t_state r_state, n_state;
    logic   r_second, n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_second         = r_second;
        o_cmd            = '0;
        o_cmd.sel_second = r_second;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_second   = 1'b0;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (!i_sts.in_ok) begin
                    o_cmd.res_err = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.fwd_init = 1'b1;
                    n_state        = S_FWD;
                end
            end
            S_FWD: begin
                o_cmd.fwd_step = 1'b1;
                if (i_sts.fwd_done) begin
                    n_state = S_SER;
                end
            end
            S_SER: begin
                if (!i_sts.day_ok) begin
                    o_cmd.res_err = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.ser_store = 1'b1;
                    if (i_sts.op == OP_ADD) begin
                        n_state = S_SUM;
                    end else if (!r_second) begin
                        n_second = 1'b1;
                        n_state  = S_CHK;
                    end else begin
                        n_state = S_DIFF;
                    end
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_LIM;
            end
            S_LIM: begin
                if (i_sts.over_lim) begin
                    o_cmd.res_sat = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.rev_init = 1'b1;
                    n_state        = S_REV;
                end
            end
            S_REV: begin
                o_cmd.rev_step = 1'b1;
                if (i_sts.rev_done) begin
                    n_state = S_MON;
                end
            end
            S_MON: begin
                o_cmd.mon_step = 1'b1;
                if (i_sts.mon_done) begin
                    o_cmd.res_date = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_DIFF: begin
                o_cmd.res_diff = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    `CDAD_ASSERT_IMP(a_second_only_diff, r_second && (r_state == S_CHK || r_state == S_FWD || r_state == S_SER), i_sts.op == OP_DIFF)
    `CDAD_ASSERT_NEXT(a_push_frees_input, o_cmd.push, o_in_ready)
    `CDAD_ASSERT(a_one_result_cmd, $onehot0({o_cmd.res_err, o_cmd.res_sat, o_cmd.res_date, o_cmd.res_diff, o_cmd.push}))

endmodule

// ----- rtl/cdad_dp.sv -----
`include "calendar_date_add_and_diff_defines.svh"

module cdad_dp #(
    parameter int unsigned MAX_YEAR       = cdad_pkg::MAX_YEAR_DEF,
    parameter int unsigned ADD_COUNT_BITS = cdad_pkg::ADD_COUNT_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cdad_pkg::t_cmd  i_cmd,
    output cdad_pkg::t_sts  o_sts,
    input  cdad_pkg::t_in   i_in_word,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output cdad_pkg::t_out  o_out_word
);
    import cdad_pkg::*;

    localparam int unsigned YW_NEED = $clog2(MAX_YEAR + 1);
    localparam int unsigned YW      = (YW_NEED > YEAR_BITS) ? YW_NEED : YEAR_BITS;
    localparam int unsigned LIM     = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                                      + MAX_YEAR / 400 - 1;
    localparam int unsigned ADD_USE = (ADD_COUNT_BITS < ADD_BITS) ? ADD_COUNT_BITS : ADD_BITS;
    localparam int unsigned SW_NEED = $clog2(LIM + (1 << ADD_USE));
    localparam int unsigned SW      = (SW_NEED > DIFF_BITS + 1) ? SW_NEED : DIFF_BITS + 1;

    localparam logic [ADD_BITS-1:0] ADD_MASK = ADD_BITS'((64'd1 << ADD_USE) - 64'd1);
    localparam logic [SW-1:0]       LIM_V    = SW'(LIM);
    localparam logic [YW-1:0]       MAX_Y    = YW'(MAX_YEAR);

    t_in                   r_in, n_in;
    logic [YW-1:0]         r_yr, n_yr;
    logic [8:0]            r_sub, n_sub;
    logic [SW-1:0]         r_dn, n_dn;
    t_stage                r_stg, n_stg;
    logic [1:0]            r_cnt, n_cnt;
    logic                  r_leap, n_leap;
    logic [MONTH_BITS-1:0] r_mo, n_mo;
    logic [SW-1:0]         r_a, n_a;
    logic [SW-1:0]         r_b, n_b;
    t_out                  r_res, n_res;
    logic                  r_ov, n_ov;
    t_out                  r_out, n_out;

    logic [YEAR_BITS-1:0]  s_year;
    logic [MONTH_BITS-1:0] s_mon;
    logic [DAY_BITS-1:0]   s_day;
    logic [YW-1:0]         ystep;
    logic [SW-1:0]         dstep;
    logic                  fwd_go;
    logic                  cap;
    logic                  rev_go;
    logic                  rev_leap;
    logic [DAY_BITS-1:0]   mlen;
    logic                  mon_go;
    logic [SW-1:0]         ser;
    logic [SW-1:0]         diff;
    logic                  sat;
    logic [YW-1:0]         year_out;

    // date selected for checking and serial numbering
    always_comb begin
        if (i_cmd.sel_second) begin
            s_year = r_in.second_year;
            s_mon  = r_in.second_month;
            s_day  = r_in.second_day;
        end else begin
            s_year = r_in.first_year;
            s_mon  = r_in.first_month;
            s_day  = r_in.first_day;
        end
    end

    assign ystep    = YW'(year_step(r_stg));
    assign dstep    = SW'(day_step(r_stg));
    assign fwd_go   = (r_yr >= ystep);
    assign cap      = ((r_stg == STG_100) || (r_stg == STG_1)) && (r_cnt == 2'd3);
    assign rev_go   = (r_dn >= dstep) && !cap;
    assign rev_leap = is_leap_rem(r_sub);
    assign mlen     = month_len(r_mo, rev_leap);
    assign mon_go   = (r_dn >= SW'(mlen)) && (r_mo < MONTH_BITS'(MONTHS));
    assign ser      = r_dn + SW'(days_before(s_mon)) + SW'(r_leap && (s_mon > 4'd2))
                      + SW'(s_day) - SW'(1);
    assign diff     = (r_a >= r_b) ? (r_a - r_b) : (r_b - r_a);
    assign sat      = (diff > SW'(DIFF_MAX));
    assign year_out = r_yr + YW'(r_sub) + YW'(1);

    always_comb begin
        o_sts.op       = r_in.operation;
        o_sts.in_ok    = (s_year != '0) && (YW'(s_year) <= MAX_Y)
                         && (s_mon inside {[4'd1:4'd12]}) && (s_day != '0);
        o_sts.fwd_done = (r_stg == STG_1) && !fwd_go;
        o_sts.day_ok   = (s_day <= month_len(s_mon, r_leap));
        o_sts.over_lim = (r_dn > LIM_V);
        o_sts.rev_done = (r_stg == STG_1) && !rev_go;
        o_sts.mon_done = !mon_go;
        o_sts.out_free = !r_ov || i_out_ready;
    end

    always_comb begin
        n_in   = r_in;
        n_yr   = r_yr;
        n_sub  = r_sub;
        n_dn   = r_dn;
        n_stg  = r_stg;
        n_cnt  = r_cnt;
        n_leap = r_leap;
        n_mo   = r_mo;
        n_a    = r_a;
        n_b    = r_b;
        n_res  = r_res;
        n_ov   = r_ov;
        n_out  = r_out;

        if (i_cmd.load) begin
            n_in = i_in_word;
        end

        // date to serial: peel years off by stage, counting days
        if (i_cmd.fwd_init) begin
            n_yr  = YW'(s_year) - YW'(1);
            n_dn  = '0;
            n_stg = STG_400;
            n_cnt = '0;
        end
        if (i_cmd.fwd_step) begin
            if (fwd_go) begin
                n_yr = r_yr - ystep;
                n_dn = r_dn + dstep;
            end else begin
                if (r_stg == STG_400) begin
                    n_leap = is_leap_rem(r_yr[8:0]);
                end
                if (r_stg != STG_1) begin
                    n_stg = t_stage'(r_stg + 2'd1);
                    n_cnt = '0;
                end
            end
        end
        if (i_cmd.ser_store) begin
            if (i_cmd.sel_second) begin
                n_b = ser;
            end else begin
                n_a = ser;
            end
        end
        if (i_cmd.sum) begin
            n_dn = r_a + SW'(r_in.days_to_add & ADD_MASK);
        end

        // serial to date: peel days off by stage, counting years
        if (i_cmd.rev_init) begin
            n_yr  = '0;
            n_sub = '0;
            n_stg = STG_400;
            n_cnt = '0;
            n_mo  = MONTH_BITS'(1);
        end
        if (i_cmd.rev_step) begin
            if (rev_go) begin
                n_dn  = r_dn - dstep;
                n_cnt = r_cnt + 2'd1;
                if (r_stg == STG_400) begin
                    n_yr = r_yr + ystep;
                end else begin
                    n_sub = r_sub + year_step(r_stg);
                end
            end else if (r_stg != STG_1) begin
                n_stg = t_stage'(r_stg + 2'd1);
                n_cnt = '0;
            end
        end
        if (i_cmd.mon_step && mon_go) begin
            n_dn = r_dn - SW'(mlen);
            n_mo = r_mo + MONTH_BITS'(1);
        end

        if (i_cmd.res_err) begin
            n_res            = '0;
            n_res.error_flag = 1'b1;
        end
        if (i_cmd.res_sat) begin
            n_res              = '0;
            n_res.result_year  = YEAR_BITS'(MAX_YEAR);
            n_res.result_month = MONTH_BITS'(MONTHS);
            n_res.result_day   = DAY_BITS'(31);
            n_res.error_flag   = 1'b1;
        end
        if (i_cmd.res_date) begin
            n_res              = '0;
            n_res.result_year  = year_out[YEAR_BITS-1:0];
            n_res.result_month = r_mo;
            n_res.result_day   = r_dn[DAY_BITS-1:0] + DAY_BITS'(1);
        end
        if (i_cmd.res_diff) begin
            n_res                = '0;
            n_res.day_difference = sat ? DIFF_MAX : diff[DIFF_BITS-1:0];
            n_res.error_flag     = sat;
        end

        // output word register
        if (i_cmd.push) begin
            n_out = r_res;
            n_ov  = 1'b1;
        end else if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_yr   <= n_yr;
        r_sub  <= n_sub;
        r_dn   <= n_dn;
        r_stg  <= n_stg;
        r_cnt  <= n_cnt;
        r_leap <= n_leap;
        r_mo   <= n_mo;
        r_a    <= n_a;
        r_b    <= n_b;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

    `CDAD_ASSERT_NEXT(a_date_in_range, i_cmd.res_date, r_res.result_month >= 4'd1 && r_res.result_month <= 4'd12 && r_res.result_day >= 5'd1)
    `CDAD_ASSERT_NEXT(a_diff_no_date, i_cmd.res_diff, r_res.result_year == '0 && r_res.result_month == '0 && r_res.result_day == '0)
    `CDAD_ASSERT_NEXT(a_sum_within_limit, i_cmd.rev_init, r_dn <= LIM_V)

endmodule

// ----- rtl/calendar_date_add_and_diff.sv -----
// channel   direction  handshake                  word
// input     in         i_in_valid / o_in_ready    i_in_word  (cdad_pkg::t_in)
// output    out        o_out_valid / i_out_ready  o_out_word (cdad_pkg::t_out)
//
// up to two words held: one being worked, one waiting in the output register
// the year loop steps 400, 100, 4 and 1 years, one step a cycle
// date to serial: the year loop, then month offset, leap day and day added in a single sum
// add word: serial, sum, limit check, then years and months back; difference word: two serials and their gap
// bad year, month or zero day ends at its check, before its year loop; a day past month end only after the year loop
// synchronous active-low reset clears the controller and the output valid bit
// a result waiting on i_out_ready holds only the next word's last cycle, not its intake

`include "calendar_date_add_and_diff_defines.svh"

module calendar_date_add_and_diff #(
    parameter int unsigned MAX_YEAR       = cdad_pkg::MAX_YEAR_DEF,
    parameter int unsigned ADD_COUNT_BITS = cdad_pkg::ADD_COUNT_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  cdad_pkg::t_in   i_in_word,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output cdad_pkg::t_out  o_out_word
);
    import cdad_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cdad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cdad_dp #(
        .MAX_YEAR       (MAX_YEAR),
        .ADD_COUNT_BITS (ADD_COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    `CDAD_ASSERT_NEXT(a_accept_starts_check, i_in_valid && o_in_ready, !o_in_ready)
    `CDAD_ASSERT_IMP(a_push_needs_room, cmd.push, !o_out_valid || i_out_ready)
    `CDAD_ASSERT_NEXT(a_push_shows_word, cmd.push, o_out_valid)

endmodule
